>>> rtl/blr_pkg.sv
package blr_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int COLOR_BITS = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic setup;
      logic advance;
   } blr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
   } blr_sts_type;

endpackage

>>> rtl/blr_if.sv
interface blr_req_if #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic signed [COORD_BITS-1:0]      start_x;
   logic signed [COORD_BITS-1:0]      start_y;
   logic signed [COORD_BITS-1:0]      end_x;
   logic signed [COORD_BITS-1:0]      end_y;
   logic [blr_pkg::COLOR_BITS-1:0]    line_color;

   modport source (
      output valid, start_x, start_y, end_x, end_y, line_color,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, end_x, end_y, line_color,
      output ready
   );
endinterface

interface blr_rsp_if #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic signed [COORD_BITS-1:0]      pixel_x;
   logic signed [COORD_BITS-1:0]      pixel_y;
   logic [blr_pkg::COLOR_BITS-1:0]    pixel_color;
   logic                              last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
      output ready
   );
endinterface

>>> rtl/blr_ctrl.sv
module blr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output blr_pkg::blr_cmd_type cmd,
   input  blr_pkg::blr_sts_type sts
);
   import blr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RUN);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.setup   = (state_ff == ST_SETUP);
   assign cmd.advance = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd.advance && sts.last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/blr_datapath.sv
module blr_datapath #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  blr_pkg::blr_cmd_type             cmd,
   output blr_pkg::blr_sts_type             sts,
   input  logic [COORD_BITS-1:0]            start_x,
   input  logic [COORD_BITS-1:0]            start_y,
   input  logic [COORD_BITS-1:0]            end_x,
   input  logic [COORD_BITS-1:0]            end_y,
   input  logic [blr_pkg::COLOR_BITS-1:0]   line_color,
   output logic [COORD_BITS-1:0]            pixel_x,
   output logic [COORD_BITS-1:0]            pixel_y,
   output logic [blr_pkg::COLOR_BITS-1:0]   pixel_color,
   output logic                             last_pixel
);
   import blr_pkg::*;

   localparam int C = COORD_BITS;

   // Captured request.
   logic [C-1:0]          ax_ff, ay_ff, bx_ff, by_ff;
   logic [COLOR_BITS-1:0] color_ff;

   // Walk state.
   logic [C-1:0] major_ff, major_in;
   logic [C-1:0] minor_ff, minor_in;
   logic [C-1:0] major_end_ff, major_end_in;
   logic [C-1:0] d_major_ff, d_major_in;
   logic [C-1:0] d_minor_ff, d_minor_in;
   logic [C:0]   err_ff, err_in;
   logic         step_up_ff, step_up_in;
   logic         steep_ff, steep_in;

   // Setup arithmetic, all deltas C+1 bits two's complement.
   logic [C:0] dx, dy, mag_dx, mag_dy, maj_delta, min_delta, mag_maj, mag_min;
   logic       swap_ends;
   logic [C:0] err_dec, err_fix;

   always_comb begin
      dx        = {bx_ff[C-1], bx_ff} - {ax_ff[C-1], ax_ff};
      dy        = {by_ff[C-1], by_ff} - {ay_ff[C-1], ay_ff};
      mag_dx    = dx[C] ? (~dx + 1'b1) : dx;
      mag_dy    = dy[C] ? (~dy + 1'b1) : dy;
      steep_in  = (mag_dy > mag_dx);
      maj_delta = steep_in ? dy : dx;
      min_delta = steep_in ? dx : dy;
      mag_maj   = steep_in ? mag_dy : mag_dx;
      mag_min   = steep_in ? mag_dx : mag_dy;
      // A falling major delta means the endpoints are walked from the far end.
      swap_ends = maj_delta[C];
      d_major_in = mag_maj[C-1:0];
      d_minor_in = mag_min[C-1:0];
      step_up_in = (min_delta != '0) && (min_delta[C] == swap_ends);
      if (swap_ends) begin
         major_end_in = steep_in ? ay_ff : ax_ff;
      end else begin
         major_end_in = steep_in ? by_ff : bx_ff;
      end

      // One Bresenham step.
      err_dec = err_ff - {1'b0, d_minor_ff};
      err_fix = err_dec + {1'b0, d_major_ff};

      if (cmd.setup) begin
         if (swap_ends) begin
            major_in = steep_in ? by_ff : bx_ff;
            minor_in = steep_in ? bx_ff : by_ff;
         end else begin
            major_in = steep_in ? ay_ff : ax_ff;
            minor_in = steep_in ? ax_ff : ay_ff;
         end
         err_in = {2'b00, d_major_in[C-1:1]};
      end else begin
         major_in = major_ff + C'(1);
         if (err_dec[C]) begin
            minor_in = step_up_ff ? (minor_ff + C'(1)) : (minor_ff - C'(1));
            err_in   = err_fix;
         end else begin
            minor_in = minor_ff;
            err_in   = err_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff    <= start_x;
         ay_ff    <= start_y;
         bx_ff    <= end_x;
         by_ff    <= end_y;
         color_ff <= line_color;
      end
      if (cmd.setup) begin
         steep_ff     <= steep_in;
         major_end_ff <= major_end_in;
         d_major_ff   <= d_major_in;
         d_minor_ff   <= d_minor_in;
         step_up_ff   <= step_up_in;
      end
      if (cmd.setup || cmd.advance) begin
         major_ff <= major_in;
         minor_ff <= minor_in;
         err_ff   <= err_in;
      end
   end

   assign sts.last    = (major_ff == major_end_ff);
   assign last_pixel  = sts.last;
   assign pixel_x     = steep_ff ? minor_ff : major_ff;
   assign pixel_y     = steep_ff ? major_ff : minor_ff;
   assign pixel_color = color_ff;

endmodule

>>> rtl/bresenham_line_rasterizer_core.sv
// After a request is accepted, the setup state comes before the first pixel is offered.
// A line has N pixels, N = max(|dx|, |dy|) + 1. The single error-update loop emits one pixel
// a cycle while pixels are taken at once; a pixel is held while the receiver is not ready.
// A new request is taken only after the last pixel of the previous line is taken.
// Reset is synchronous and active high; it returns the controller to idle and drops any line.
module bresenham_line_rasterizer_core #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   blr_req_if.sink   req_if,
   blr_rsp_if.source rsp_if
);
   import blr_pkg::*;

   blr_cmd_type cmd;
   blr_sts_type sts;

   blr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   blr_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .sts         (sts),
      .start_x     (req_if.start_x),
      .start_y     (req_if.start_y),
      .end_x       (req_if.end_x),
      .end_y       (req_if.end_y),
      .line_color  (req_if.line_color),
      .pixel_x     (rsp_if.pixel_x),
      .pixel_y     (rsp_if.pixel_y),
      .pixel_color (rsp_if.pixel_color),
      .last_pixel  (rsp_if.last_pixel)
   );

`ifndef SYNTH
   // An accepted request leads to its first pixel after the setup cycle.
   a_first_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> ##2 rsp_if.valid)
      else $error("first pixel not offered two cycles after request");

   // A line keeps producing pixels until its last one is taken.
   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_if.last_pixel) |=> rsp_if.valid)
      else $error("line ended before its last pixel");

   // No request is taken while a line is being emitted.
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("request accepted during a line");

   // After the last pixel is taken the block is ready for a new request.
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_pixel) |=> req_if.ready)
      else $error("block not idle after last pixel");
`endif

endmodule

>>> verif/tb_bresenham_line_rasterizer_core.sv
module tb_bresenham_line_rasterizer_core;
   import blr_pkg::*;

   localparam int COORD_BITS  = COORD_BITS_DEF;
   localparam int RANDOM_LINES = 335;
   localparam int CYCLE_LIMIT = 1000000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type             start_x;
      coord_type             start_y;
      coord_type             end_x;
      coord_type             end_y;
      logic [COLOR_BITS-1:0] color;
   } line_type;

   typedef struct packed {
      coord_type             x;
      coord_type             y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   logic clock;
   logic reset;

   blr_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   blr_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

   bresenham_line_rasterizer_core #(.COORD_BITS(COORD_BITS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   line_type  line_queue[$];
   pixel_type pixel_expect[$];

   int fail_count     = 0;
   int pixel_count    = 0;
   int lines_accepted = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   bit send_burst     = 0;
   int take_wait      = 0;
   bit take_burst     = 0;
   int hold_left      = 0;
   int hold_at        = 30;

   function automatic int mag(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic line_type make_line(int sx, int sy, int ex, int ey,
                                          logic [COLOR_BITS-1:0] color);
      line_type ln;
      ln.start_x = sx[COORD_BITS-1:0];
      ln.start_y = sy[COORD_BITS-1:0];
      ln.end_x   = ex[COORD_BITS-1:0];
      ln.end_y   = ey[COORD_BITS-1:0];
      ln.color   = color;
      return ln;
   endfunction

   // Walks the line along its major axis and queues every pixel it should produce.
   task automatic rasterize_line(input line_type ln);
      int        x0, y0, x1, y1, t;
      int        d_major, d_minor, err, dir, major, minor;
      bit        steep;
      pixel_type px;
      x0 = ln.start_x;
      y0 = ln.start_y;
      x1 = ln.end_x;
      y1 = ln.end_y;
      steep = mag(y1 - y0) > mag(x1 - x0);
      if (steep) begin
         t = x0; x0 = y0; y0 = t;
         t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      d_major = x1 - x0;
      d_minor = mag(y1 - y0);
      err = d_major / 2;
      dir = (y0 < y1) ? 1 : -1;
      minor = y0;
      for (major = x0; major <= x1; major++) begin
         if (steep) begin
            px.x = minor[COORD_BITS-1:0];
            px.y = major[COORD_BITS-1:0];
         end else begin
            px.x = major[COORD_BITS-1:0];
            px.y = minor[COORD_BITS-1:0];
         end
         px.color = ln.color;
         px.last  = (major == x1);
         pixel_expect.push_back(px);
         err -= d_minor;
         if (err < 0) begin
            minor += dir;
            err += d_major;
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at pixel %0d: %s", pixel_count, msg);
      fail_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      coord_type sx, sy, ex, ey;
      int        kind;
      reset = 1'b1;

      // Single points, full-span axis lines both ways, diagonals (ties go to x),
      // shallow and steep lines with rising and falling minor coordinate.
      line_queue.push_back(make_line(0, 0, 0, 0, 32'h0000_0000));
      line_queue.push_back(make_line(-32, -32, -32, -32, 32'hFFFF_FFFF));
      line_queue.push_back(make_line(31, 31, 31, 31, 32'h8000_0001));
      line_queue.push_back(make_line(-32, 0, 31, 0, 32'hAAAA_5555));
      line_queue.push_back(make_line(31, -5, -32, -5, 32'h5555_AAAA));
      line_queue.push_back(make_line(7, -32, 7, 31, 32'h1234_5678));
      line_queue.push_back(make_line(-7, 31, -7, -32, 32'hDEAD_BEEF));
      line_queue.push_back(make_line(-32, -32, 31, 31, 32'h0F0F_0F0F));
      line_queue.push_back(make_line(31, -32, -32, 31, 32'hF0F0_F0F0));
      line_queue.push_back(make_line(-32, 31, 31, -32, 32'h0000_FFFF));
      line_queue.push_back(make_line(0, 0, 20, 7, 32'hFFFF_0000));
      line_queue.push_back(make_line(0, 0, 20, -7, 32'h0000_0001));
      line_queue.push_back(make_line(3, -30, -4, 25, 32'h7FFF_FFFF));
      line_queue.push_back(make_line(-10, 20, 5, -28, 32'hC3C3_3C3C));
      line_queue.push_back(make_line(0, 0, 1, 0, 32'h0000_0002));
      line_queue.push_back(make_line(5, 5, 4, 6, 32'h4000_0000));

      for (int i = 0; i < RANDOM_LINES; i++) begin
         kind = $urandom_range(0, 19);
         sx = coord_type'($urandom);
         sy = coord_type'($urandom);
         ex = coord_type'($urandom);
         ey = coord_type'($urandom);
         if (kind < 4) begin
            ex = coord_type'(sx + $urandom_range(0, 8) - 4);
            ey = coord_type'(sy + $urandom_range(0, 8) - 4);
         end else if (kind == 4) begin
            ex = sx;
            ey = sy;
         end else if (kind == 5) begin
            ey = sy;
         end else if (kind == 6) begin
            ex = sx;
         end else if (kind == 7) begin
            ey = sy + (ex - sx);
         end
         line_queue.push_back(make_line(int'(sx), int'(sy), int'(ex), int'(ey), $urandom));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (line_queue.size() != 0 || pixel_expect.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Request driver: offers the head of the line queue after a random gap.
   always @(posedge clock) begin
      line_type done_line;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.start_x    <= '0;
         req_if.start_y    <= '0;
         req_if.end_x      <= '0;
         req_if.end_y      <= '0;
         req_if.line_color <= '0;
         send_gap = $urandom_range(0, 6);
      end else begin
         if (req_if.valid && req_if.ready) begin
            done_line = line_queue.pop_front();
            rasterize_line(done_line);
            lines_accepted <= lines_accepted + 1;
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 6);
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_gap > 0) begin
               req_if.valid <= 1'b0;
               send_gap--;
            end else if (line_queue.size() != 0) begin
               req_if.valid      <= 1'b1;
               req_if.start_x    <= line_queue[0].start_x;
               req_if.start_y    <= line_queue[0].start_y;
               req_if.end_x      <= line_queue[0].end_x;
               req_if.end_y      <= line_queue[0].end_y;
               req_if.line_color <= line_queue[0].color;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off so the block backs up and stalls its request side.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_at   <= 30;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (lines_accepted >= hold_at) begin
         hold_left <= 400;
         hold_at   <= hold_at + 170;
      end
   end

   // Pixel monitor: checks each taken item against the oldest prediction.
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait = $urandom_range(0, 6);
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pixel_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel x %0d y %0d",
                                         rsp_if.pixel_x, rsp_if.pixel_y));
            end else begin
               want = pixel_expect.pop_front();
               if (rsp_if.pixel_x !== want.x)
                  report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                            rsp_if.pixel_x, want.x));
               if (rsp_if.pixel_y !== want.y)
                  report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                            rsp_if.pixel_y, want.y));
               if (rsp_if.pixel_color !== want.color)
                  report_mismatch($sformatf("pixel_color %h, expected %h",
                                            rsp_if.pixel_color, want.color));
               if (rsp_if.last_pixel !== want.last)
                  report_mismatch($sformatf("last_pixel %b, expected %b",
                                            rsp_if.last_pixel, want.last));
            end
            pixel_count++;
            if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
            take_wait = take_burst ? 0 : $urandom_range(0, 6);
         end else if (take_wait > 0) begin
            take_wait--;
         end
         rsp_if.ready <= (take_wait == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
